// ===== rtl/apq_pkg.sv =====
// shared types and codes for the array priority queue
// no dependencies
package apq_pkg;

   typedef logic signed [31:0] data_type;

   typedef struct packed {
      logic     shift;
      data_type data;
   } cell_ctl_type;

   localparam logic [1:0] FUNC_INSERT  = 2'd0;
   localparam logic [1:0] FUNC_APPEND  = 2'd1;
   localparam logic [1:0] FUNC_DEQUEUE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

// ===== rtl/array_priority_queue_unit.sv =====
// Bounded priority queue of signed 32-bit values held in a chain of DEPTH cells.
// An item is a priority insert, a plain append or a dequeue of the largest entry;
// each item gives one result with status, removed value and occupancy. Work is done
// by rotating the chain through cell 0, whose entry is compared once per cycle. An
// append, a full insert, an empty dequeue and an unused code load the result in the
// accepting cycle; a priority insert takes the accepting cycle, then one turn of the
// chain with the entry placed on the way; a dequeue takes the accepting cycle, one
// turn to find the maximum and one to drop it. The result sits in an output register;
// the next item is taken once the sequencer is idle and that register is free or
// being emptied in the same cycle.
// depends on apq_pkg, apq_cell, apq_ctrl
module array_priority_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic [4:0]         rsp_occupancy
);
   import apq_pkg::*;

   cell_ctl_type     cell_ctl;
   logic [DEPTH-1:0] load_sel;
   data_type         cell_data [DEPTH];

   apq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_out_value(rsp_out_value),
      .rsp_occupancy(rsp_occupancy),
      .front        (cell_data[0]),
      .cell_ctl     (cell_ctl),
      .load_sel     (load_sel)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type right_data;

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid
         assign right_data = cell_data[i+1];
      end

      apq_cell u_cell (
         .clock     (clock),
         .cell_ctl  (cell_ctl),
         .load_sel  (load_sel[i]),
         .right_data(right_data),
         .data      (cell_data[i])
      );
   end

endmodule

// ===== rtl/apq_cell.sv =====
// one storage cell of the queue chain: loads a new entry or takes its right neighbour's
// depends on apq_pkg
module apq_cell (
   input  logic                  clock,
   input  apq_pkg::cell_ctl_type cell_ctl,
   input  logic                  load_sel,
   input  apq_pkg::data_type     right_data,
   output apq_pkg::data_type     data
);
   import apq_pkg::*;

   data_type data_ff;

   always_ff @(posedge clock) begin
      if (load_sel) begin
         data_ff <= cell_ctl.data;
      end else if (cell_ctl.shift) begin
         data_ff <= right_data;
      end
   end

   assign data = data_ff;

endmodule

// ===== rtl/apq_ctrl.sv =====
// sequencer for the queue: rotates the chain through cell 0, compares and
// injects or drops entries, holds the count and the result register
// depends on apq_pkg
module apq_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic signed [31:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_out_value,
   output logic [4:0]            rsp_occupancy,
   input  apq_pkg::data_type     front,
   output apq_pkg::cell_ctl_type cell_ctl,
   output logic [DEPTH-1:0]      load_sel
);
   import apq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INS  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DROP = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] len_ff, len_in;
   logic          flag_ff, flag_in;
   data_type      value_ff, value_in;
   data_type      best_ff, best_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   data_type      rsp_value_ff, rsp_value_in;
   logic [4:0]    rsp_occ_ff, rsp_occ_in;
   logic          rsp_load;

   logic          accept;
   logic          load;
   logic [CW-1:0] load_pos;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] count_dec;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      len_in        = len_ff;
      flag_in       = flag_ff;
      value_in      = value_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      rsp_occ_in    = 5'(count_ff);
      load          = 1'b0;
      load_pos      = len_ff;
      cell_ctl      = '{shift: 1'b0, data: front};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        value_in = req_value;
                        rem_in   = count_ff;
                        len_in   = count_ff;
                        flag_in  = 1'b0;
                        state_in = S_INS;
                     end
                  end
                  FUNC_APPEND: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        load          = 1'b1;
                        load_pos      = count_ff;
                        cell_ctl.data = req_value;
                        count_in      = count_inc;
                        rsp_load      = 1'b1;
                        rsp_occ_in    = 5'(count_inc);
                     end
                  end
                  FUNC_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        best_in  = front;
                        rem_in   = count_ff;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_INS: begin
            if (!flag_ff && ((rem_ff == '0) || !(front > value_ff))) begin
               load          = 1'b1;
               load_pos      = len_ff;
               cell_ctl.data = value_ff;
               len_in        = len_ff + CW'(1);
               flag_in       = 1'b1;
               if (rem_ff == '0) begin
                  count_in   = count_inc;
                  rsp_load   = 1'b1;
                  rsp_occ_in = 5'(count_inc);
                  state_in   = S_IDLE;
               end
            end else begin
               load           = 1'b1;
               load_pos       = len_ff - CW'(1);
               cell_ctl.shift = 1'b1;
               rem_in         = rem_ff - CW'(1);
               if ((rem_ff == CW'(1)) && flag_ff) begin
                  count_in   = count_inc;
                  rsp_load   = 1'b1;
                  rsp_occ_in = 5'(count_inc);
                  state_in   = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            load           = 1'b1;
            load_pos       = count_dec;
            cell_ctl.shift = 1'b1;
            if (front > best_ff) begin
               best_in = front;
            end
            rem_in = rem_ff - CW'(1);
            if (rem_ff == CW'(1)) begin
               rem_in   = count_ff;
               len_in   = count_ff;
               flag_in  = 1'b0;
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            cell_ctl.shift = 1'b1;
            if (!flag_ff && (front == best_ff)) begin
               flag_in = 1'b1;
               len_in  = len_ff - CW'(1);
            end else begin
               load     = 1'b1;
               load_pos = len_ff - CW'(1);
            end
            rem_in = rem_ff - CW'(1);
            if (rem_ff == CW'(1)) begin
               count_in     = count_dec;
               rsp_load     = 1'b1;
               rsp_value_in = best_ff;
               rsp_occ_in   = 5'(count_dec);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         load_sel[i] = load && (load_pos == CW'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      len_ff   <= len_in;
      flag_ff  <= flag_in;
      value_ff <= value_in;
      best_ff  <= best_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule
